// ===== hdl/wma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package wma_pkg;

   localparam int FIELD_W = 32;
   localparam int CFG_W   = 9;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LOAD,
      ST_DIVIDE,
      ST_EMIT
   } wma_state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic div_load;
      logic div_step;
      logic emit;
   } wma_cmd_type;

   typedef struct packed {
      logic item_null;
      logic window_full;
      logic div_last;
      logic out_free;
   } wma_status_type;

endpackage
`default_nettype wire

// ===== hdl/windowed_moving_average.sv =====
// A null sample goes from its transfer straight to the emit state; any other sample
// passes through the update and load states and, if its window is then full, through the
// divide state, where the restoring divider retires one quotient bit a cycle, before emit.
// The block takes no new sample until the last one is emitted: req_ready is high only in
// idle, and the emit state waits while a held result has not been taken.
// Reset sets the window length to one and clears the fill count, position and sum.
`timescale 1ns / 1ps
`default_nettype none
module windowed_moving_average #(
   parameter int WINDOW_MAX   = 256,
   parameter int SAMPLE_WIDTH = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic signed [wma_pkg::FIELD_W-1:0] req_sample,
   input  wire logic                               req_sample_null,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed      [wma_pkg::FIELD_W-1:0] rsp_average,
   output logic                                    rsp_average_valid,
   output logic                                    rsp_null_in_middle_error,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic        [wma_pkg::CFG_W-1:0]   csr_window_length
);

   import wma_pkg::*;

   wma_cmd_type    cmd;
   wma_status_type status;

   assign csr_ready = 1'b1;

   wma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wma_dp #(
      .WINDOW_MAX   (WINDOW_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dp (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .status                   (status),
      .req_sample               (req_sample),
      .req_sample_null          (req_sample_null),
      .csr_valid                (csr_valid),
      .csr_window_length        (csr_window_length),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_average              (rsp_average),
      .rsp_average_valid        (rsp_average_valid),
      .rsp_null_in_middle_error (rsp_null_in_middle_error)
   );

endmodule
`default_nettype wire

// ===== hdl/wma_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wma_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/wma_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wma_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire wma_pkg::wma_status_type status,
   output wma_pkg::wma_cmd_type         cmd
);

   import wma_pkg::*;

   wma_state_type state_ff;
   wma_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = status.item_null ? ST_EMIT : ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = status.window_full ? ST_DIVIDE : ST_EMIT;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== hdl/wma_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wma_dp #(
   parameter int WINDOW_MAX   = 256,
   parameter int SAMPLE_WIDTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire wma_pkg::wma_cmd_type                   cmd,
   output wma_pkg::wma_status_type                     status,
   input  wire logic signed [wma_pkg::FIELD_W-1:0]     req_sample,
   input  wire logic                                   req_sample_null,
   input  wire logic                                   csr_valid,
   input  wire logic        [wma_pkg::CFG_W-1:0]       csr_window_length,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed      [wma_pkg::FIELD_W-1:0]     rsp_average,
   output logic                                        rsp_average_valid,
   output logic                                        rsp_null_in_middle_error
);

   import wma_pkg::*;

   localparam int RING_DEPTH = (WINDOW_MAX > 511) ? 511 : WINDOW_MAX;
   localparam int ADDR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int SUM_W      = SAMPLE_WIDTH + CFG_W;
   localparam int CNT_W      = $clog2(SUM_W);
   localparam logic [CFG_W-1:0] WIN_CAP = CFG_W'(RING_DEPTH);

   logic        [SAMPLE_WIDTH-1:0] sample_ff;
   logic                           null_ff;
   logic        [CFG_W-1:0]        window_ff;
   logic        [ADDR_W-1:0]       pos_ff;
   logic        [CFG_W-1:0]        fill_ff;
   logic signed [SUM_W-1:0]        sum_ff;
   logic signed [SUM_W-1:0]        sum_in;
   logic        [SUM_W-1:0]        quo_ff;
   logic        [CFG_W-1:0]        rem_ff;
   logic                           neg_ff;
   logic        [CNT_W-1:0]        cnt_ff;
   logic                           rsp_valid_ff;
   logic signed [FIELD_W-1:0]      rsp_average_ff;
   logic                           rsp_average_valid_ff;
   logic                           rsp_error_ff;

   logic        [SAMPLE_WIDTH-1:0] old_sample;
   logic        [CFG_W-1:0]        window_req;
   logic        [CFG_W:0]          pos_inc;
   logic        [ADDR_W-1:0]       pos_next;
   logic signed [SUM_W-1:0]        old_ext;
   logic signed [SUM_W-1:0]        new_ext;
   logic        [SUM_W-1:0]        sum_mag;
   logic        [CFG_W:0]          trial;
   logic                           trial_ok;
   logic        [SUM_W-1:0]        quo_signed;
   logic                           window_full;

   wma_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (pos_ff),
      .wr_data (sample_ff),
      .rd_en   (cmd.capture),
      .rd_addr (pos_ff),
      .rd_data (old_sample)
   );

   assign window_full = (fill_ff >= window_ff);

   always_comb begin
      if (csr_window_length == '0) begin
         window_req = CFG_W'(1);
      end else if (csr_window_length > WIN_CAP) begin
         window_req = WIN_CAP;
      end else begin
         window_req = csr_window_length;
      end
   end

   assign pos_inc  = (CFG_W + 1)'(pos_ff) + (CFG_W + 1)'(1);
   assign pos_next = (pos_inc >= {1'b0, window_ff}) ? '0 : ADDR_W'(pos_inc);

   assign old_ext = SUM_W'($signed(old_sample));
   assign new_ext = SUM_W'($signed(sample_ff));
   assign sum_in  = sum_ff - (window_full ? old_ext : '0) + new_ext;
   assign sum_mag = sum_ff[SUM_W-1] ? $unsigned(-sum_ff) : $unsigned(sum_ff);

   assign trial    = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_ok = (trial >= {1'b0, window_ff});

   assign quo_signed = neg_ff ? (-quo_ff) : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= CFG_W'(1);
         pos_ff    <= '0;
         fill_ff   <= '0;
         sum_ff    <= '0;
      end else if (csr_valid) begin
         window_ff <= window_req;
         pos_ff    <= '0;
         fill_ff   <= '0;
         sum_ff    <= '0;
      end else if (cmd.update) begin
         pos_ff <= pos_next;
         sum_ff <= sum_in;
         if (!window_full) begin
            fill_ff <= fill_ff + CFG_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= SAMPLE_WIDTH'($unsigned(req_sample));
         null_ff   <= req_sample_null;
      end
      if (cmd.div_load) begin
         quo_ff <= sum_mag;
         rem_ff <= '0;
         neg_ff <= sum_ff[SUM_W-1];
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[SUM_W-2:0], trial_ok};
         rem_ff <= trial_ok ? CFG_W'(trial - {1'b0, window_ff}) : CFG_W'(trial);
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (null_ff) begin
            rsp_average_ff       <= '0;
            rsp_average_valid_ff <= 1'b0;
            rsp_error_ff         <= (fill_ff != '0);
         end else if (window_full) begin
            rsp_average_ff       <= FIELD_W'($signed(quo_signed));
            rsp_average_valid_ff <= 1'b1;
            rsp_error_ff         <= 1'b0;
         end else begin
            rsp_average_ff       <= '0;
            rsp_average_valid_ff <= 1'b0;
            rsp_error_ff         <= 1'b0;
         end
      end
   end

   always_comb begin
      status.item_null   = req_sample_null;
      status.window_full = window_full;
      status.div_last    = (cnt_ff == CNT_W'(SUM_W - 1));
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_average              = rsp_average_ff;
   assign rsp_average_valid        = rsp_average_valid_ff;
   assign rsp_null_in_middle_error = rsp_error_ff;

endmodule
`default_nettype wire
